[rtl/average_pool_stream_assert.svh]
// Assertion macros for the average pooling block.
// Included by the modules that carry concurrent assertions.
`ifndef AVERAGE_POOL_STREAM_ASSERT_SVH
`define AVERAGE_POOL_STREAM_ASSERT_SVH
`ifndef ASSERT_OFF
`define APS_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("lbl");
`define APS_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("lbl");
`else
`define APS_ASSERT_IMPL(lbl, a, c)
`define APS_ASSERT_NEXT(lbl, a, c)
`endif
`endif

[rtl/aps_pkg.sv]
// Package for the average pooling block: state codes, command and status types.
// No dependencies.
`timescale 1ns / 1ps
package aps_pkg;
  typedef enum logic [2:0] {
    ST_IDLE, ST_WRITE, ST_READ, ST_DIV, ST_OUT
  } aps_state_t;

  typedef struct packed {
    logic store;
    logic start_sum;
    logic start_div;
    logic load_out;
    logic advance;
  } aps_cmd_t;

  typedef struct packed {
    logic hit;
    logic sum_done;
    logic div_done;
  } aps_stat_t;
endpackage

[rtl/aps_stream_if.sv]
// Valid/ready stream interface with a generic payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface aps_stream_if #(parameter int W = 16) ();
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/aps_ctrl.sv]
// Controller state machine for the average pooling block.
// Depends on aps_pkg.
`timescale 1ns / 1ps
module aps_ctrl import aps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_busy,
  input  aps_stat_t stat,
  output aps_cmd_t  cmd
);
  aps_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.store = 1'b1;
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (stat.hit) begin
          cmd.start_sum = 1'b1;
          state_nxt = ST_READ;
        end else begin
          cmd.advance = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        if (stat.sum_done) begin
          cmd.start_div = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (stat.div_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_busy) begin
          cmd.load_out = 1'b1;
          cmd.advance = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

[rtl/aps_datapath.sv]
// Datapath: line store, window sum accumulator, divider and position counters.
// Depends on aps_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "average_pool_stream_assert.svh"
module aps_datapath import aps_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int POOL_MAX  = 8,
  parameter int DATA_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  aps_cmd_t                    cmd,
  output aps_stat_t                   stat,
  input  logic signed [DATA_BITS-1:0] pixel,
  input  logic                        cfg_en,
  input  logic [1:0]                  cfg_idx,
  input  logic [10:0]                 cfg_data,
  output logic signed [DATA_BITS-1:0] avg,
  output logic [9:0]                  orow,
  output logic [9:0]                  ocol,
  output logic                        olast
);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int PW = $clog2(POOL_MAX);
  localparam int AW = CW + PW;
  localparam int SW = DATA_BITS + 2 * PW + 1;
  localparam int QW = SW;

  logic [3:0]  wsz_r, stp_r;
  logic [10:0] pw_r, ph_r;
  logic [10:0] row_r, col_r;

  logic [4:0]  ws;
  logic [3:0]  st;
  logic [12:0] w, h;
  always_comb begin
    ws = (wsz_r == 4'd0) ? 5'd1 : (wsz_r > 4'(POOL_MAX) && POOL_MAX < 16) ?
         5'(POOL_MAX) : {1'b0, wsz_r};
    st = (stp_r == 4'd0) ? 4'd1 : stp_r;
    w = (pw_r == 11'd0) ? 13'd1 : (13'(pw_r) > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) :
        13'(pw_r);
    h = (ph_r == 11'd0) ? 13'd1 : (ph_r > 11'd1024) ? 13'd1024 : 13'(ph_r);
  end

  logic [12:0] r, c;
  assign r = (13'(row_r) >= h) ? 13'd0 : 13'(row_r);
  assign c = (13'(col_r) >= w) ? 13'd0 : 13'(col_r);

  // Stride phase counters track (pos + 1 - ws) mod st and (pos + 1 - ws) / st incrementally.
  logic [3:0] rph_r, cph_r;
  logic [9:0] oro_r, oco_r;
  logic       rok_r, cok_r;

  logic [DATA_BITS-1:0] mem [2**AW];
  logic [AW-1:0] waddr, raddr;
  logic [DATA_BITS-1:0] rdata_r;
  assign waddr = {r[PW-1:0], c[CW-1:0]};

  logic [12:0] r0, c0;
  logic [3:0]  ki_r, kk_r;
  logic        busy_r, rdv_r, last_rd_r;
  assign r0 = r + 13'd1 - 13'(ws);
  assign c0 = c + 13'd1 - 13'(ws);
  logic [12:0] ra_row, ra_col;
  assign ra_row = r0 + 13'(ki_r);
  assign ra_col = c0 + 13'(kk_r);
  assign raddr = {ra_row[PW-1:0], ra_col[CW-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.store) mem[waddr] <= pixel;
    rdata_r <= mem[raddr];
  end

  logic signed [SW-1:0] sum_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; rdv_r <= 1'b0; last_rd_r <= 1'b0;
      ki_r <= '0; kk_r <= '0;
    end else begin
      rdv_r <= busy_r;
      last_rd_r <= 1'b0;
      if (cmd.start_sum) begin
        busy_r <= 1'b1; ki_r <= '0; kk_r <= '0;
      end else if (busy_r) begin
        if (5'(ki_r) + 5'd1 == ws) begin
          ki_r <= '0;
          if (5'(kk_r) + 5'd1 == ws) begin
            busy_r <= 1'b0; last_rd_r <= 1'b1;
          end else kk_r <= kk_r + 4'd1;
        end else ki_r <= ki_r + 4'd1;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.start_sum) sum_r <= '0;
    else if (rdv_r) sum_r <= sum_r + SW'($signed(rdata_r));
  end
  logic sum_done_r;
  always_ff @(posedge clk) begin
    if (!rst_n) sum_done_r <= 1'b0;
    else sum_done_r <= last_rd_r;
  end

  // Restoring divider on the magnitude, one quotient bit per cycle.
  localparam int DCW = $clog2(QW + 1);
  logic [QW-1:0]  mag_r, quo_r;
  logic [QW:0]    rem_r;
  logic [7:0]     dvs_r;
  logic           neg_r, dbusy_r, ddone_r;
  logic [DCW-1:0] dcnt_r;
  logic [QW:0]    trial;
  assign trial = {rem_r[QW-1:0], mag_r[QW-1]};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0; ddone_r <= 1'b0; dcnt_r <= '0;
    end else begin
      ddone_r <= 1'b0;
      if (cmd.start_div) begin
        dbusy_r <= 1'b1;
        dcnt_r <= DCW'(QW);
      end else if (dbusy_r) begin
        dcnt_r <= dcnt_r - DCW'(1);
        if (dcnt_r == DCW'(1)) begin
          dbusy_r <= 1'b0; ddone_r <= 1'b1;
        end
      end
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      neg_r <= sum_r[SW-1];
      mag_r <= sum_r[SW-1] ? QW'(-sum_r) : QW'(sum_r);
      dvs_r <= 8'(ws) * 8'(ws);
      rem_r <= '0;
      quo_r <= '0;
    end else if (dbusy_r) begin
      mag_r <= mag_r << 1;
      if (trial >= (QW+1)'(dvs_r)) begin
        rem_r <= trial - (QW+1)'(dvs_r);
        quo_r <= {quo_r[QW-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        quo_r <= {quo_r[QW-2:0], 1'b0};
      end
    end
  end

  logic [9:0] lr, lc;
  assign lr = oro_r;
  assign lc = oco_r;
  logic [12:0] rem_h, rem_w;
  assign rem_h = h - 13'(ws);
  assign rem_w = w - 13'(ws);
  // Last window: the next window would pass the plane edge.
  logic last_r_hit, last_c_hit;
  assign last_r_hit = (r + 13'(st) >= h);
  assign last_c_hit = (c + 13'(st) >= w);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      avg <= neg_r ? DATA_BITS'(-quo_r) : DATA_BITS'(quo_r);
      orow <= lr;
      ocol <= lc;
      olast <= last_r_hit && last_c_hit && (rem_h < 13'(1) << 12) && (rem_w < 13'(1) << 12);
    end
  end

  logic hit;
  assign hit = rok_r && cok_r && (rph_r == 4'd0) && (cph_r == 4'd0);
  assign stat.hit = hit;
  assign stat.sum_done = sum_done_r;
  assign stat.div_done = ddone_r;

  logic [3:0] wsz_new;
  assign wsz_new = (cfg_idx == 2'd0) ? cfg_data[3:0] : wsz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsz_r <= 4'd2; stp_r <= 4'd2; pw_r <= 11'd1024; ph_r <= 11'd1024;
      row_r <= '0; col_r <= '0;
      rph_r <= '0; cph_r <= '0; oro_r <= '0; oco_r <= '0;
      rok_r <= 1'b0; cok_r <= 1'b0;
    end else if (cfg_en) begin
      case (cfg_idx)
        2'd0: wsz_r <= cfg_data[3:0];
        2'd1: stp_r <= cfg_data[3:0];
        2'd2: pw_r <= cfg_data;
        default: ph_r <= cfg_data;
      endcase
      row_r <= '0; col_r <= '0;
      rph_r <= '0; cph_r <= '0; oro_r <= '0; oco_r <= '0;
      rok_r <= (wsz_new <= 4'd1); cok_r <= (wsz_new <= 4'd1);
    end else if (cmd.advance) begin
      if (c + 13'd1 >= w) begin
        col_r <= '0;
        cph_r <= '0; oco_r <= '0; cok_r <= (ws == 5'd1);
        if (r + 13'd1 >= h) begin
          row_r <= '0; rph_r <= '0; oro_r <= '0; rok_r <= (ws == 5'd1);
        end else begin
          row_r <= 11'(r + 13'd1);
          if (r + 13'd2 >= 13'(ws)) begin
            if (rok_r) begin
              if (rph_r + 4'd1 == st) begin
                rph_r <= '0; oro_r <= oro_r + 10'd1;
              end else rph_r <= rph_r + 4'd1;
            end
            rok_r <= 1'b1;
          end
        end
      end else begin
        col_r <= 11'(c + 13'd1);
        if (c + 13'd2 >= 13'(ws)) begin
          if (cok_r) begin
            if (cph_r + 4'd1 == st) begin
              cph_r <= '0; oco_r <= oco_r + 10'd1;
            end else cph_r <= cph_r + 4'd1;
          end
          cok_r <= 1'b1;
        end
      end
    end
  end

  `APS_ASSERT_NEXT(a_sum_then_div, sum_done_r, !busy_r)
  `APS_ASSERT_IMPL(a_div_idle, cmd.start_sum, !dbusy_r)
  `APS_ASSERT_IMPL(a_hit_phase, hit, (rph_r < st) && (cph_r < st))
endmodule

[rtl/average_pool_stream.sv]
// Top level of the strided average pooling block.
// Depends on aps_pkg, aps_stream_if, aps_ctrl and aps_datapath.
//
//   channel  | dir | payload
//   in_      | in  | pixel_value[15:0]
//   out_     | out | average_value, out_row, out_col, plane_last
//   cfg_     | in  | register index and write data
//
// A word without a window returns to idle after the write state; a completing
// word is also held by the single line store read port, which reads the ws*ws
// window words, and the one-bit-per-cycle divider. The output register frees the input side
// while a result waits. Reset is synchronous; the line store is not cleared.
`timescale 1ns / 1ps
module average_pool_stream import aps_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int POOL_MAX  = 8,
  parameter int DATA_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  aps_stream_if.sink  in_s,
  aps_stream_if.source out_s,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);
  aps_cmd_t  cmd;
  aps_stat_t stat;
  logic signed [DATA_BITS-1:0] avg;
  logic [9:0] orow, ocol;
  logic olast, ov_r;

  aps_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_s.valid), .in_ready(in_s.ready),
    .out_busy(ov_r && !out_s.ready), .stat, .cmd
  );

  aps_datapath #(.MAX_WIDTH(MAX_WIDTH), .POOL_MAX(POOL_MAX), .DATA_BITS(DATA_BITS)) u_dp (
    .clk, .rst_n, .cmd, .stat, .pixel(in_s.data[DATA_BITS-1:0]),
    .cfg_en(cfg_we), .cfg_idx(cfg_index), .cfg_data,
    .avg, .orow, .ocol, .olast
  );

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (cmd.load_out) ov_r <= 1'b1;
    else if (out_s.ready) ov_r <= 1'b0;
  end

  assign out_s.valid = ov_r;
  assign out_s.data = {avg, orow, ocol, olast};
endmodule

[tb/sv/tb.sv]
// Self-checking testbench for average_pool_stream: streams pixel planes, predicts every
// pooled word and compares it field by field. Depends on aps_pkg, aps_stream_if, the RTL.
`timescale 1ns / 1ps
module tb;
  import aps_pkg::*;

  localparam int WIN_IDX = 0;
  localparam int STEP_IDX = 1;
  localparam int WIDTH_IDX = 2;
  localparam int HEIGHT_IDX = 3;
  localparam int SETTLE_CYCLES = 150;

  typedef struct packed {
    logic signed [15:0] average_value;
    logic [9:0] out_row;
    logic [9:0] out_col;
    logic plane_last;
  } pool_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [10:0] cfg_data = '0;

  aps_stream_if #(.W(16)) pix_if ();
  aps_stream_if #(.W(37)) pool_if ();

  average_pool_stream uut (
    .clk(clk), .rst_n(rst_n), .in_s(pix_if.sink), .out_s(pool_if.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  initial begin
    pix_if.valid = 1'b0;
    pix_if.data = '0;
    pool_if.ready = 1'b0;
  end

  // Predictor state.
  logic [3:0] win_reg = 4'd2;
  logic [3:0] step_reg = 4'd2;
  logic [10:0] width_reg = 11'd1024;
  logic [10:0] height_reg = 11'd1024;
  logic signed [15:0] line_rows [8][1024];
  int unsigned pix_row = 0;
  int unsigned pix_col = 0;

  pool_word_t pending_pools[$];
  int errors = 0;
  int pixels_sent = 0;
  int pools_seen = 0;
  bit steady = 0;
  int hold_seq = 0;

  task automatic pool_pixel(input logic signed [15:0] px);
    int unsigned ws, st, w, h, r, c, r0, c0, lr, lc;
    int total;
    pool_word_t pw;
    ws = (win_reg == 0) ? 1 : (win_reg > 8) ? 8 : win_reg;
    st = (step_reg == 0) ? 1 : step_reg;
    w = (width_reg == 0) ? 1 : (width_reg > 1024) ? 1024 : width_reg;
    h = (height_reg == 0) ? 1 : (height_reg > 1024) ? 1024 : height_reg;
    r = (pix_row >= h) ? 0 : pix_row;
    c = (pix_col >= w) ? 0 : pix_col;
    line_rows[r % 8][c] = px;
    if (r + 1 >= ws && c + 1 >= ws && (r + 1 - ws) % st == 0 && (c + 1 - ws) % st == 0) begin
      r0 = r + 1 - ws;
      c0 = c + 1 - ws;
      total = 0;
      for (int k = 0; k < ws; k++)
        for (int i = 0; i < ws; i++)
          total += line_rows[(r0 + i) % 8][c0 + k];
      lr = (h - ws) / st;
      lc = (w - ws) / st;
      pw.average_value = 16'(total / int'(ws * ws));
      pw.out_row = 10'(r0 / st);
      pw.out_col = 10'(c0 / st);
      pw.plane_last = (r0 / st == lr) && (c0 / st == lc);
      pending_pools.push_back(pw);
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    pix_row = r;
    pix_col = c;
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (steady || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic send_pixel(input logic signed [15:0] px);
    int g;
    g = pick_gap();
    if (g > 0) begin
      pix_if.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.data <= px;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    pool_pixel(px);
    pixels_sent++;
  endtask

  task automatic drain();
    pix_if.valid <= 1'b0;
    while (pending_pools.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      WIN_IDX: win_reg = val[3:0];
      STEP_IDX: step_reg = val[3:0];
      WIDTH_IDX: width_reg = val;
      default: height_reg = val;
    endcase
    pix_row = 0;
    pix_col = 0;
  endtask

  task automatic setup(input int ws, input int st, input int w, input int h);
    drain();
    write_reg(WIN_IDX, 11'(ws));
    write_reg(STEP_IDX, 11'(st));
    write_reg(WIDTH_IDX, 11'(w));
    write_reg(HEIGHT_IDX, 11'(h));
  endtask

  function automatic logic [15:0] rand_pixel();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 16'h7fff;
    if (p == 1) return 16'h8000;
    return 16'($urandom);
  endfunction

  task automatic test_extremes();
    setup(8, 1, 8, 8);
    for (int i = 0; i < 64; i++) send_pixel(16'h7fff);
    setup(8, 8, 8, 8);
    for (int i = 0; i < 64; i++) send_pixel(16'h8000);
    setup(1, 0, 3, 2);
    for (int i = 0; i < 6; i++) send_pixel(i[0] ? 16'h8000 : 16'h7fff);
  endtask

  task automatic test_out_of_range();
    setup(15, 15, 9, 9);
    for (int i = 0; i < 81; i++) send_pixel(rand_pixel());
    setup(0, 1, 0, 0);
    for (int i = 0; i < 4; i++) send_pixel(rand_pixel());
    setup(2, 1, 2047, 2047);
    for (int i = 0; i < 1030; i++) send_pixel(rand_pixel());
    setup(2, 3, 2047, 3);
    for (int i = 0; i < 40; i++) send_pixel(rand_pixel());
  endtask

  task automatic test_small_plane();
    setup(8, 2, 5, 5);
    for (int i = 0; i < 25; i++) send_pixel(rand_pixel());
    setup(4, 1, 10, 3);
    for (int i = 0; i < 30; i++) send_pixel(rand_pixel());
  endtask

  task automatic test_restart_midplane();
    setup(3, 2, 7, 7);
    for (int i = 0; i < 20; i++) send_pixel(rand_pixel());
    drain();
    write_reg(STEP_IDX, 11'd1);
    for (int i = 0; i < 49; i++) send_pixel(rand_pixel());
  endtask

  task automatic test_backpressure();
    setup(2, 1, 6, 6);
    steady = 1;
    hold_seq++;
    for (int i = 0; i < 72; i++) send_pixel(rand_pixel());
    steady = 0;
  endtask

  task automatic test_random_planes();
    int ws, st, w, h, planes, n;
    int target;
    target = pixels_sent + 100;
    while (pixels_sent < target) begin
      ws = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
      st = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
      w = $urandom_range(1, 18);
      h = $urandom_range(1, 10);
      if ($urandom_range(0, 5) != 0) begin
        if (w < 8) w = $urandom_range(8, 18);
        if (h < 8) h = $urandom_range(8, 10);
      end
      planes = $urandom_range(1, 3);
      n = planes * w * h;
      if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n);
      if (n > target - pixels_sent) n = target - pixels_sent;
      steady = ($urandom_range(0, 4) == 0);
      setup(ws, st, w, h);
      for (int i = 0; i < n; i++) send_pixel(rand_pixel());
    end
    steady = 0;
  endtask

  // Result side: random stalls plus a long hold-off when requested.
  initial begin
    int seen_seq, hold_cnt, stall;
    seen_seq = 0;
    hold_cnt = 0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_seq != seen_seq) begin
        seen_seq = hold_seq;
        hold_cnt = 600;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        pool_if.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        pool_if.ready <= 1'b0;
      end else begin
        stall = pick_gap();
        pool_if.ready <= (stall == 0);
      end
    end
  end

  always @(posedge clk) begin
    pool_word_t got, want;
    if (rst_n && pool_if.valid && pool_if.ready) begin
      got = pool_if.data;
      pools_seen++;
      if (pending_pools.size() == 0) begin
        $error("unexpected pooled word %h", got);
        errors++;
      end else begin
        want = pending_pools.pop_front();
        if (got.average_value !== want.average_value) begin
          $error("average_value expected %0d actual %0d", want.average_value,
                 got.average_value);
          errors++;
        end
        if (got.out_row !== want.out_row) begin
          $error("out_row expected %0d actual %0d", want.out_row, got.out_row);
          errors++;
        end
        if (got.out_col !== want.out_col) begin
          $error("out_col expected %0d actual %0d", want.out_col, got.out_col);
          errors++;
        end
        if (got.plane_last !== want.plane_last) begin
          $error("plane_last expected %0d actual %0d", want.plane_last, got.plane_last);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_out_of_range();
    test_small_plane();
    test_restart_midplane();
    test_backpressure();
    test_random_planes();
    drain();
    if (pending_pools.size() != 0) errors++;
    $display("Sent %0d pixels and checked %0d pooled words over many window, step and",
             pixels_sent, pools_seen);
    $display("plane settings, including out-of-range registers and a long output stall.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
